>>> rtl/core/lcdc_pkg.sv
// Package for the dot-matrix LCD controller: constants, codes, the annunciator
// table and the command/status types shared by the controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package lcdc_pkg;

   localparam int RAM_BYTES = 512;
   localparam int RAM_AW    = $clog2(RAM_BYTES);
   localparam int DOT_ROWS  = 31;
   localparam int ROW_BYTES = 12;
   localparam int SEG_COUNT = 18;

   localparam logic [15:0] RAM_BASE          = 16'hF800;
   localparam logic [15:0] REG_RANGE_ADDR    = 16'hF030;
   localparam logic [15:0] REG_MODE_ADDR     = 16'hF031;
   localparam logic [15:0] REG_CONTRAST_ADDR = 16'hF032;
   localparam logic [3:0]  PAD_NIBBLE        = 4'hC;
   localparam logic [7:0]  RANGE_MASK        = 8'h07;
   localparam logic [7:0]  MODE_MASK         = 8'h07;
   localparam logic [7:0]  CONTRAST_MASK     = 8'h1F;
   localparam logic [RAM_AW-1:0] ROW_OFFSET  = RAM_AW'(16);

   localparam logic [9:0] ON_BASE    = 10'd20;
   localparam logic [7:0] ALPHA_MAX  = 8'd255;
   localparam logic [4:0] OFF_KNEE   = 5'd8;
   localparam logic [7:0] TEST_ON    = 8'd80;
   localparam logic [7:0] TEST_OFF   = 8'd20;

   localparam logic [2:0] MODE_DOTS_OFF = 3'd4;
   localparam logic [2:0] MODE_NORMAL   = 3'd5;
   localparam logic [2:0] MODE_TEST     = 3'd6;

   typedef enum logic [2:0] {
      REQ_READ    = 3'd0,
      REQ_WRITE   = 3'd1,
      REQ_FRAME   = 3'd2,
      REQ_PIXEL   = 3'd3,
      REQ_SEGMENT = 3'd4
   } req_code_type;

   typedef struct packed {
      logic accept;
      logic sweep;
      logic commit;
   } lcdc_cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic out_busy;
   } lcdc_sts_type;

   typedef struct packed {
      logic [7:0] mask;
      logic [3:0] byte_sel;
   } seg_bit_type;

   function automatic seg_bit_type seg_lookup(input logic [4:0] seg);
      seg_bit_type r;
      unique case (seg)
         5'd0:    r = '{mask: 8'h10, byte_sel: 4'h0};
         5'd1:    r = '{mask: 8'h04, byte_sel: 4'h0};
         5'd2:    r = '{mask: 8'h10, byte_sel: 4'h1};
         5'd3:    r = '{mask: 8'h02, byte_sel: 4'h1};
         5'd4:    r = '{mask: 8'h40, byte_sel: 4'h2};
         5'd5:    r = '{mask: 8'h40, byte_sel: 4'h3};
         5'd6:    r = '{mask: 8'h80, byte_sel: 4'h4};
         5'd7:    r = '{mask: 8'h40, byte_sel: 4'h5};
         5'd8:    r = '{mask: 8'h01, byte_sel: 4'h5};
         5'd9:    r = '{mask: 8'h20, byte_sel: 4'h7};
         5'd10:   r = '{mask: 8'h02, byte_sel: 4'h7};
         5'd11:   r = '{mask: 8'h10, byte_sel: 4'h8};
         5'd12:   r = '{mask: 8'h01, byte_sel: 4'h8};
         5'd13:   r = '{mask: 8'h20, byte_sel: 4'h9};
         5'd14:   r = '{mask: 8'h40, byte_sel: 4'hA};
         5'd15:   r = '{mask: 8'h08, byte_sel: 4'hA};
         5'd16:   r = '{mask: 8'h80, byte_sel: 4'hB};
         5'd17:   r = '{mask: 8'h10, byte_sel: 4'hB};
         default: r = '{mask: 8'h00, byte_sel: 4'h0};
      endcase
      return r;
   endfunction

endpackage

>>> rtl/core/lcdc_if.sv
// Valid/ready channel interfaces for the LCD controller request and response.
// No dependencies.
`timescale 1ns / 1ps

interface lcdc_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] req_type;
   logic [15:0] address;
   logic [7:0] write_data;
   logic [4:0] pixel_row;
   logic [6:0] pixel_col;
   logic [4:0] segment;

   modport source (output valid, req_type, address, write_data, pixel_row, pixel_col,
                   segment, input ready);
   modport sink (input valid, req_type, address, write_data, pixel_row, pixel_col,
                 segment, output ready);
endinterface

interface lcdc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       hit;
   logic [7:0] alpha;
   logic       visible;
   logic       dirty;

   modport source (output valid, read_data, hit, alpha, visible, dirty, input ready);
   modport sink (input valid, read_data, hit, alpha, visible, dirty, output ready);
endinterface

>>> rtl/core/lcdc_ctrl.sv
// Controller state machine for the LCD controller: clearing sweep, accept, execute.
// Depends on lcdc_pkg.
`timescale 1ns / 1ps

module lcdc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lcdc_pkg::lcdc_sts_type sts,
   output lcdc_pkg::lcdc_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!sts.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/core/lcdc_dp.sv
// Datapath for the LCD controller: display RAM, control registers, alpha logic
// and the response register. Depends on lcdc_pkg.
`timescale 1ns / 1ps

module lcdc_dp #(
   parameter int DOT_ROWS  = lcdc_pkg::DOT_ROWS,
   parameter int ROW_BYTES = lcdc_pkg::ROW_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lcdc_pkg::lcdc_cmd_type cmd,
   output lcdc_pkg::lcdc_sts_type sts,
   input  logic [2:0]             req_type,
   input  logic [15:0]            address,
   input  logic [7:0]             write_data,
   input  logic [4:0]             pixel_row,
   input  logic [6:0]             pixel_col,
   input  logic [4:0]             segment,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             read_data,
   output logic                   hit,
   output logic [7:0]             alpha,
   output logic                   visible,
   output logic                   dirty
);

   localparam int AW = lcdc_pkg::RAM_AW;

   logic [7:0]    ram_mem [lcdc_pkg::RAM_BYTES];
   logic [7:0]    ram_rdata_ff;
   logic [AW-1:0] ram_raddr;
   logic [AW-1:0] ram_waddr;
   logic [7:0]    ram_wdata;
   logic          ram_we;

   logic [AW-1:0] sweep_ff, sweep_in;

   logic [2:0]  req_type_ff;
   logic [15:0] address_ff;
   logic [7:0]  write_data_ff;
   logic [4:0]  pixel_row_ff;
   logic [6:0]  pixel_col_ff;
   logic [4:0]  segment_ff;

   logic [2:0] range_ff, range_in;
   logic [2:0] mode_ff, mode_in;
   logic [4:0] contrast_ff, contrast_in;
   logic       redraw_ff, redraw_in;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_rd_ff, out_rd_in;
   logic       out_hit_ff, out_hit_in;
   logic [7:0] out_alpha_ff, out_alpha_in;
   logic       out_vis_ff, out_vis_in;
   logic       out_dirty_ff, out_dirty_in;

   lcdc_pkg::seg_bit_type seg_in_bit;
   lcdc_pkg::seg_bit_type seg_ex_bit;

   logic       ram_hit;
   logic       pad;
   logic       ram_wr_exec;
   logic       change;
   logic [9:0] on_raw;
   logic [4:0] off_base;
   logic [7:0] on_alpha;
   logic [7:0] off_alpha;
   logic       draw;
   logic       dots_blank;
   logic       show_status;

   assign seg_in_bit = lcdc_pkg::seg_lookup(segment);
   assign seg_ex_bit = lcdc_pkg::seg_lookup(segment_ff);

   always_comb begin
      case (req_type) inside
         lcdc_pkg::REQ_PIXEL:
            ram_raddr = AW'({pixel_row, 4'b0000}) + lcdc_pkg::ROW_OFFSET
                        + AW'(pixel_col[6:3]);
         lcdc_pkg::REQ_SEGMENT:
            ram_raddr = AW'(seg_in_bit.byte_sel);
         default:
            ram_raddr = address[AW-1:0];
      endcase
   end

   assign ram_hit = address_ff[15:AW] == lcdc_pkg::RAM_BASE[15:AW];
   assign pad     = address_ff[3:0] >= lcdc_pkg::PAD_NIBBLE;
   assign ram_wr_exec = (req_type_ff == lcdc_pkg::REQ_WRITE) && ram_hit && !pad;

   assign ram_we    = cmd.sweep || (cmd.commit && ram_wr_exec);
   assign ram_waddr = cmd.sweep ? sweep_ff : address_ff[AW-1:0];
   assign ram_wdata = cmd.sweep ? 8'h00 : write_data_ff;

   always_ff @(posedge clock) begin
      if (ram_we) begin
         ram_mem[ram_waddr] <= ram_wdata;
      end
      if (cmd.accept) begin
         ram_rdata_ff <= ram_mem[ram_raddr];
      end
   end

   assign sweep_in = cmd.sweep ? sweep_ff + AW'(1) : sweep_ff;
   assign sts = '{sweep_last: (sweep_ff == AW'(lcdc_pkg::RAM_BYTES - 1)),
                  out_busy:   (out_valid_ff && !rsp_ready)};

   always_comb begin
      on_raw   = lcdc_pkg::ON_BASE + {1'b0, contrast_ff, 4'b0000};
      off_base = contrast_ff - lcdc_pkg::OFF_KNEE;
      on_alpha = (on_raw > 10'(lcdc_pkg::ALPHA_MAX)) ? lcdc_pkg::ALPHA_MAX : on_raw[7:0];
      off_alpha = (contrast_ff > lcdc_pkg::OFF_KNEE)
                  ? ({off_base, 3'b000} - 8'(off_base)) : 8'h00;
      draw        = 1'b1;
      dots_blank  = 1'b0;
      show_status = 1'b0;
      case (mode_ff)
         lcdc_pkg::MODE_DOTS_OFF: begin
            dots_blank = 1'b1;
         end
         lcdc_pkg::MODE_NORMAL: begin
            show_status = 1'b1;
         end
         lcdc_pkg::MODE_TEST: begin
            dots_blank  = 1'b1;
            show_status = 1'b1;
            on_alpha    = lcdc_pkg::TEST_ON;
            off_alpha   = lcdc_pkg::TEST_OFF;
         end
         default: draw = 1'b0;
      endcase
   end

   always_comb begin
      out_rd_in    = 8'h00;
      out_hit_in   = 1'b0;
      out_alpha_in = 8'h00;
      out_vis_in   = 1'b0;
      out_dirty_in = 1'b0;
      range_in     = range_ff;
      mode_in      = mode_ff;
      contrast_in  = contrast_ff;
      change       = 1'b0;
      case (req_type_ff) inside
         lcdc_pkg::REQ_READ, lcdc_pkg::REQ_WRITE: begin
            if (ram_hit) begin
               out_hit_in = 1'b1;
               out_rd_in  = pad ? 8'h00 : ram_rdata_ff;
               change     = ram_wr_exec && (ram_rdata_ff != write_data_ff);
            end else if (address_ff == lcdc_pkg::REG_RANGE_ADDR) begin
               out_hit_in = 1'b1;
               out_rd_in  = {5'b00000, range_ff};
               range_in   = write_data_ff[2:0] & lcdc_pkg::RANGE_MASK[2:0];
            end else if (address_ff == lcdc_pkg::REG_MODE_ADDR) begin
               out_hit_in = 1'b1;
               out_rd_in  = {5'b00000, mode_ff};
               mode_in    = write_data_ff[2:0] & lcdc_pkg::MODE_MASK[2:0];
            end else if (address_ff == lcdc_pkg::REG_CONTRAST_ADDR) begin
               out_hit_in  = 1'b1;
               out_rd_in   = {3'b000, contrast_ff};
               contrast_in = write_data_ff[4:0] & lcdc_pkg::CONTRAST_MASK[4:0];
            end
            if (req_type_ff == lcdc_pkg::REQ_READ) begin
               range_in    = range_ff;
               mode_in     = mode_ff;
               contrast_in = contrast_ff;
            end else begin
               out_rd_in = 8'h00;
               change = change || (range_in != range_ff) || (mode_in != mode_ff)
                        || (contrast_in != contrast_ff);
            end
         end
         lcdc_pkg::REQ_FRAME: begin
            out_dirty_in = redraw_ff;
         end
         lcdc_pkg::REQ_PIXEL: begin
            if ((pixel_row_ff < 5'(DOT_ROWS))
                && (pixel_col_ff < 7'(8 * ROW_BYTES)) && draw) begin
               out_vis_in   = 1'b1;
               out_alpha_in = (!dots_blank && ram_rdata_ff[~pixel_col_ff[2:0]])
                              ? on_alpha : off_alpha;
            end
         end
         lcdc_pkg::REQ_SEGMENT: begin
            if ((segment_ff < 5'(lcdc_pkg::SEG_COUNT)) && draw && show_status) begin
               out_vis_in   = 1'b1;
               out_alpha_in = ((ram_rdata_ff & seg_ex_bit.mask) != 8'h00)
                              ? on_alpha : off_alpha;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      redraw_in = redraw_ff;
      if (cmd.commit) begin
         if (req_type_ff == lcdc_pkg::REQ_FRAME) begin
            redraw_in = 1'b0;
         end else if (change) begin
            redraw_in = 1'b1;
         end
      end
   end

   assign out_valid_in = cmd.commit || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= '0;
         range_ff     <= '0;
         mode_ff      <= '0;
         contrast_ff  <= '0;
         redraw_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         sweep_ff     <= sweep_in;
         redraw_ff    <= redraw_in;
         out_valid_ff <= out_valid_in;
         if (cmd.commit) begin
            range_ff    <= range_in;
            mode_ff     <= mode_in;
            contrast_ff <= contrast_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_type_ff   <= req_type;
         address_ff    <= address;
         write_data_ff <= write_data;
         pixel_row_ff  <= pixel_row;
         pixel_col_ff  <= pixel_col;
         segment_ff    <= segment;
      end
      if (cmd.commit) begin
         out_rd_ff    <= out_rd_in;
         out_hit_ff   <= out_hit_in;
         out_alpha_ff <= out_alpha_in;
         out_vis_ff   <= out_vis_in;
         out_dirty_ff <= out_dirty_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign read_data = out_rd_ff;
   assign hit       = out_hit_ff;
   assign alpha     = out_alpha_ff;
   assign visible   = out_vis_ff;
   assign dirty     = out_dirty_ff;

endmodule

>>> rtl/core/lcd_controller_ram_and_scan.sv
// Top level of the dot-matrix LCD controller: joins the controller and datapath.
// Depends on lcdc_pkg, lcdc_if, lcdc_ctrl and lcdc_dp.
//
//   Channel   Direction  Carries
//   req_bus   in         req_type, address, write_data, pixel_row, pixel_col, segment
//   rsp_bus   out        read_data, hit, alpha, visible, dirty
//
// A transaction is accepted in the idle state, which reads the display RAM, whose
// read data is registered; the execute state then computes the result and commits it.
// After reset a clearing sweep writes zero to all 512 RAM bytes, one per cycle,
// while req_bus.ready stays low.
// A new request is accepted while a response waits; the commit then waits until
// the response register is free.
`timescale 1ns / 1ps

module lcd_controller_ram_and_scan #(
   parameter int DOT_ROWS  = lcdc_pkg::DOT_ROWS,
   parameter int ROW_BYTES = lcdc_pkg::ROW_BYTES
) (
   input  logic            clock,
   input  logic            reset,
   lcdc_req_if.sink        req_bus,
   lcdc_rsp_if.source      rsp_bus
);

   lcdc_pkg::lcdc_cmd_type cmd;
   lcdc_pkg::lcdc_sts_type sts;

   lcdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lcdc_dp #(
      .DOT_ROWS  (DOT_ROWS),
      .ROW_BYTES (ROW_BYTES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_type   (req_bus.req_type),
      .address    (req_bus.address),
      .write_data (req_bus.write_data),
      .pixel_row  (req_bus.pixel_row),
      .pixel_col  (req_bus.pixel_col),
      .segment    (req_bus.segment),
      .rsp_valid  (rsp_bus.valid),
      .rsp_ready  (rsp_bus.ready),
      .read_data  (rsp_bus.read_data),
      .hit        (rsp_bus.hit),
      .alpha      (rsp_bus.alpha),
      .visible    (rsp_bus.visible),
      .dirty      (rsp_bus.dirty)
   );

endmodule
